[hw/rtl/serx_pkg.sv]
// shared types and constants for the submesh extract and remap block
package serx_pkg;

  localparam int unsigned MAX_VERTICES = 4096;
  localparam int unsigned ADDR_W       = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = ADDR_W + 1;
  localparam int unsigned NUM_W        = 12;
  localparam int unsigned TAG_W        = 3;
  localparam int unsigned ENTRY_W      = NUM_W + 1;

  typedef enum logic [1:0] {
    REQ_START    = 2'd0,
    REQ_VERTEX   = 2'd1,
    REQ_TRIANGLE = 2'd2
  } req_kind_e;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_OVERFLOW = 2'd2
  } out_kind_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TAG_W-1:0] vertex_segment;
    logic [NUM_W-1:0] corner_a;
    logic [NUM_W-1:0] corner_b;
    logic [NUM_W-1:0] corner_c;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       out_kind;
    logic [NUM_W-1:0] source_number;
    logic [NUM_W-1:0] new_number;
    logic [NUM_W-1:0] new_a;
    logic [NUM_W-1:0] new_b;
    logic [NUM_W-1:0] new_c;
  } out_res_t;

endpackage

[hw/rtl/serx_ram.sv]
// generic single-write single-read ram with registered read data
module serx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/submesh_extract_remap_core.sv]
// top level of the submesh extract and remap block
//
// Requests arrive on the in channel (valid/stall) and carry a start, vertex
// or triangle code. Results leave on the out channel (valid/stall) from an
// output register. The part tag to keep is set through cfg_we_i/cfg_wdata_i.
// A start request clears both counters; the remap store needs no clearing
// pass, since only entries below the loaded-vertex count are used and
// every loaded vertex writes its entry (kept or not).
// A vertex request's result, if any, is in the output register the cycle
// after acceptance.
// A triangle request reads the remap store once per corner through its single
// read port, corners a, b and c in turn; ST_FIN then forms the result.
// A vertex past store capacity is dropped; a matching one reports overflow.
// The block takes a new request only when idle and the output register is
// empty or is being emptied in that cycle; while the receiver stalls, the
// result holds and the in channel stalls too.
// Reset clears the counters, the tag register and the output valid.
module submesh_extract_remap_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [serx_pkg::TAG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  serx_pkg::in_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output serx_pkg::out_res_t             out_res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_B,
    ST_RD_C,
    ST_FIN
  } state_e;

  state_e                          state_q, state_d;
  logic [serx_pkg::TAG_W-1:0]      target_q, target_d;
  logic [serx_pkg::CNT_W-1:0]      seen_q, seen_d;
  logic [serx_pkg::NUM_W-1:0]      kept_q, kept_d;
  logic [serx_pkg::NUM_W-1:0]      corner_b_q, corner_b_d;
  logic [serx_pkg::NUM_W-1:0]      corner_c_q, corner_c_d;
  logic                            in_range_q, in_range_d;
  logic                            tri_ok_q, tri_ok_d;
  logic [serx_pkg::NUM_W-1:0]      na_q, na_d;
  logic [serx_pkg::NUM_W-1:0]      nb_q, nb_d;
  logic                            out_valid_q, out_valid_d;
  serx_pkg::out_res_t              out_res_q, out_res_d;

  logic                            ram_we;
  logic [serx_pkg::ADDR_W-1:0]     ram_waddr;
  logic [serx_pkg::ENTRY_W-1:0]    ram_wdata;
  logic                            ram_re;
  logic [serx_pkg::ADDR_W-1:0]     ram_raddr;
  logic [serx_pkg::ENTRY_W-1:0]    ram_rdata;

  logic                            out_free;
  logic                            accept;
  logic                            match;
  logic                            full;
  logic                            hit_c;

  serx_ram #(
    .WIDTH (serx_pkg::ENTRY_W),
    .DEPTH (serx_pkg::MAX_VERTICES)
  ) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign match      = (in_req_i.vertex_segment == target_q);
  assign full       = (seen_q == serx_pkg::CNT_W'(serx_pkg::MAX_VERTICES));
  assign hit_c      = tri_ok_q && in_range_q && ram_rdata[serx_pkg::NUM_W];

  always_comb begin
    state_d     = state_q;
    target_d    = cfg_we_i ? cfg_wdata_i : target_q;
    seen_d      = seen_q;
    kept_d      = kept_q;
    corner_b_d  = corner_b_q;
    corner_c_d  = corner_c_q;
    in_range_d  = in_range_q;
    tri_ok_d    = tri_ok_q;
    na_d        = na_q;
    nb_d        = nb_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    ram_we      = 1'b0;
    ram_waddr   = seen_q[serx_pkg::ADDR_W-1:0];
    ram_wdata   = {match, kept_q};
    ram_re      = 1'b0;
    ram_raddr   = in_req_i.corner_a;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_i.req_type)
            serx_pkg::REQ_START: begin
              seen_d = '0;
              kept_d = '0;
            end
            serx_pkg::REQ_VERTEX: begin
              if (full) begin
                if (match) begin
                  out_valid_d                = 1'b1;
                  out_res_d                  = '0;
                  out_res_d.out_kind         = serx_pkg::KIND_OVERFLOW;
                  out_res_d.source_number    = '1;
                end
              end else begin
                seen_d = seen_q + serx_pkg::CNT_W'(1);
                ram_we = 1'b1;
                if (match) begin
                  kept_d                     = kept_q + serx_pkg::NUM_W'(1);
                  out_valid_d                = 1'b1;
                  out_res_d                  = '0;
                  out_res_d.out_kind         = serx_pkg::KIND_VERTEX;
                  out_res_d.source_number    = seen_q[serx_pkg::NUM_W-1:0];
                  out_res_d.new_number       = kept_q;
                end
              end
            end
            serx_pkg::REQ_TRIANGLE: begin
              ram_re     = 1'b1;
              ram_raddr  = in_req_i.corner_a;
              in_range_d = ({1'b0, in_req_i.corner_a} < seen_q);
              corner_b_d = in_req_i.corner_b;
              corner_c_d = in_req_i.corner_c;
              state_d    = ST_RD_B;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_B: begin
        tri_ok_d   = in_range_q && ram_rdata[serx_pkg::NUM_W];
        na_d       = ram_rdata[serx_pkg::NUM_W-1:0];
        ram_re     = 1'b1;
        ram_raddr  = corner_b_q;
        in_range_d = ({1'b0, corner_b_q} < seen_q);
        state_d    = ST_RD_C;
      end
      ST_RD_C: begin
        tri_ok_d   = tri_ok_q && in_range_q && ram_rdata[serx_pkg::NUM_W];
        nb_d       = ram_rdata[serx_pkg::NUM_W-1:0];
        ram_re     = 1'b1;
        ram_raddr  = corner_c_q;
        in_range_d = ({1'b0, corner_c_q} < seen_q);
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          if (hit_c) begin
            out_valid_d        = 1'b1;
            out_res_d          = '0;
            out_res_d.out_kind = serx_pkg::KIND_TRIANGLE;
            out_res_d.new_a    = na_q;
            out_res_d.new_b    = nb_q;
            out_res_d.new_c    = ram_rdata[serx_pkg::NUM_W-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      seen_q      <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      target_q    <= target_d;
      seen_q      <= seen_d;
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    corner_b_q <= corner_b_d;
    corner_c_q <= corner_c_d;
    in_range_q <= in_range_d;
    tri_ok_q   <= tri_ok_d;
    na_q       <= na_d;
    nb_q       <= nb_d;
    out_res_q  <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule
